// ===== design/vhdl_token_boundary_lexer_top_assert.svh =====
// assertion macros for the vhdl token boundary lexer
`ifndef VHDL_TOKEN_BOUNDARY_LEXER_TOP_ASSERT_SVH
`define VHDL_TOKEN_BOUNDARY_LEXER_TOP_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define VTBL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer check failed");

// consequent holds in the cycle after the antecedent
`define VTBL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer check failed");

`endif

// ===== design/vtbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbl_pkg
// token kind codes, lexer modes and byte classes for the vhdl lexer
// ----------------------------------------------------------------------------
package vtbl_pkg;

   // token kinds
   localparam logic [4:0] K_WS      = 5'd0;
   localparam logic [4:0] K_COMMENT = 5'd1;
   localparam logic [4:0] K_AMP     = 5'd2;
   localparam logic [4:0] K_LPAREN  = 5'd3;
   localparam logic [4:0] K_RPAREN  = 5'd4;
   localparam logic [4:0] K_PLUS    = 5'd5;
   localparam logic [4:0] K_COMMA   = 5'd6;
   localparam logic [4:0] K_MINUS   = 5'd7;
   localparam logic [4:0] K_DOT     = 5'd8;
   localparam logic [4:0] K_SEMI    = 5'd9;
   localparam logic [4:0] K_BAR     = 5'd10;
   localparam logic [4:0] K_LBRACK  = 5'd11;
   localparam logic [4:0] K_RBRACK  = 5'd12;
   localparam logic [4:0] K_DSTAR   = 5'd13;
   localparam logic [4:0] K_STAR    = 5'd14;
   localparam logic [4:0] K_NE      = 5'd15;
   localparam logic [4:0] K_SLASH   = 5'd16;
   localparam logic [4:0] K_ASSIGN  = 5'd17;
   localparam logic [4:0] K_COLON   = 5'd18;
   localparam logic [4:0] K_LE      = 5'd19;
   localparam logic [4:0] K_BOX     = 5'd20;
   localparam logic [4:0] K_LT      = 5'd21;
   localparam logic [4:0] K_ARROW   = 5'd22;
   localparam logic [4:0] K_EQ      = 5'd23;
   localparam logic [4:0] K_GE      = 5'd24;
   localparam logic [4:0] K_GT      = 5'd25;
   localparam logic [4:0] K_EXTID   = 5'd26;
   localparam logic [4:0] K_ABSLIT  = 5'd27;
   localparam logic [4:0] K_CHARLIT = 5'd28;
   localparam logic [4:0] K_STRLIT  = 5'd29;
   localparam logic [4:0] K_BITLIT  = 5'd30;
   localparam logic [4:0] K_IDENT   = 5'd31;

   // configuration register indexes
   localparam logic [1:0] REG_SKIP_WS  = 2'd0;
   localparam logic [1:0] REG_SKIP_CMT = 2'd1;
   localparam logic [1:0] REG_BASE     = 2'd2;

   // byte codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_C2    = 8'hc2;
   localparam logic [7:0] CH_A0    = 8'ha0;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_EXCL  = 8'h21;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_RBRK  = 8'h5d;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_BAR   = 8'h7c;

   // lexer modes
   typedef enum logic [21:0] {
      M_IDLE      = 22'h000001,
      M_WS        = 22'h000002,
      M_WS_C2     = 22'h000004,
      M_START_C2  = 22'h000008,
      M_DASH      = 22'h000010,
      M_COMMENT   = 22'h000020,
      M_COMPOUND  = 22'h000040,
      M_EXT       = 22'h000080,
      M_EXT_BS    = 22'h000100,
      M_NUM       = 22'h000200,
      M_NUM_EXP   = 22'h000400,
      M_CHAR_OPEN = 22'h000800,
      M_CHAR_TAIL = 22'h001000,
      M_STR       = 22'h002000,
      M_STR_END   = 22'h004000,
      M_STR_ESC   = 22'h008000,
      M_BIT       = 22'h010000,
      M_BIT_END   = 22'h020000,
      M_BIT_ESC   = 22'h040000,
      M_BASE      = 22'h080000,
      M_IDENT     = 22'h100000,
      M_IDENT_C2  = 22'h200000
   } lex_mode_type;

   // kind lookup result
   typedef struct packed {
      logic       hit;
      logic [4:0] kind;
   } kind_hit_type;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_letter(logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
   endfunction

   function automatic logic ident_byte(logic [7:0] b);
      return is_digit(b) || is_letter(b) || (b == CH_UNDER) || b[7];
   endfunction

   function automatic logic num_byte(logic [7:0] b);
      return is_digit(b) || is_letter(b) || (b == CH_UNDER) || (b == CH_HASH)
         || (b == CH_COLON) || (b == CH_DOT);
   endfunction

   function automatic logic is_compound_lead(logic [7:0] b);
      return (b == CH_STAR) || (b == CH_SLASH) || (b == CH_COLON) || (b == CH_LT)
         || (b == CH_EQ) || (b == CH_GT);
   endfunction

   // single delimiter kind
   function automatic kind_hit_type single_kind(logic [7:0] b);
      kind_hit_type r;
      r.hit = 1'b1;
      case (b)
         CH_AMP:   r.kind = K_AMP;
         CH_LPAR:  r.kind = K_LPAREN;
         CH_RPAR:  r.kind = K_RPAREN;
         CH_PLUS:  r.kind = K_PLUS;
         CH_COMMA: r.kind = K_COMMA;
         CH_DOT:   r.kind = K_DOT;
         CH_SEMI:  r.kind = K_SEMI;
         CH_BAR, CH_EXCL: r.kind = K_BAR;
         CH_LBRK:  r.kind = K_LBRACK;
         CH_RBRK:  r.kind = K_RBRACK;
         CH_STAR:  r.kind = K_STAR;
         CH_SLASH: r.kind = K_SLASH;
         CH_COLON: r.kind = K_COLON;
         CH_LT:    r.kind = K_LT;
         CH_EQ:    r.kind = K_EQ;
         CH_GT:    r.kind = K_GT;
         default: begin
            r.hit  = 1'b0;
            r.kind = K_WS;
         end
      endcase
      return r;
   endfunction

   // compound delimiter kind
   function automatic kind_hit_type pair_kind(logic [7:0] a, logic [7:0] b);
      kind_hit_type r;
      r.hit  = 1'b1;
      r.kind = K_WS;
      if (a == CH_STAR && b == CH_STAR) r.kind = K_DSTAR;
      else if (a == CH_SLASH && b == CH_EQ) r.kind = K_NE;
      else if (a == CH_COLON && b == CH_EQ) r.kind = K_ASSIGN;
      else if (a == CH_LT && b == CH_EQ) r.kind = K_LE;
      else if (a == CH_LT && b == CH_GT) r.kind = K_BOX;
      else if (a == CH_EQ && b == CH_GT) r.kind = K_ARROW;
      else if (a == CH_GT && b == CH_EQ) r.kind = K_GE;
      else r.hit = 1'b0;
      return r;
   endfunction

endpackage

// ===== design/vhdl_token_boundary_lexer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhdl_token_boundary_lexer_top
// groups a byte stream into vhdl tokens with kind, start and length
// ----------------------------------------------------------------------------
// Source bytes enter on the req_ stream, one byte per transfer; a zero byte
// ends the source, flushes any open token and restarts offsets at zero.
// Tokens leave on the rsp_ stream: tdata carries kind, start and length,
// tlast marks the final token caused by one source byte. Register writes
// arrive on the csr_ channel (always ready); the user must make them only
// while idle (not enforced). Each accepted byte is lexed combinationally
// by the state transition logic and its tokens (zero to three) are loaded
// into a three-entry result buffer; the first token is visible the cycle
// after the byte transfer. A byte is taken when the buffer is empty or its
// last entry leaves in that cycle, so bytes causing at most one token
// stream at one per cycle unless the receiver stalls, which holds the buffer
// and drops req_tready; a byte causing several tokens holds off the next
// byte while they drain. Reset clears the registers, lexer state and buffer.
// ----------------------------------------------------------------------------
module vhdl_token_boundary_lexer_top
   import vtbl_pkg::*;
#(
   parameter int LENGTH_BITS = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // source byte stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // src_byte
   // token stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // token_kind, token_start, token_length
   output logic [((5 + OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                   rsp_tlast,   // last_result
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);

   localparam int FIELD_BITS = 5 + OFFSET_BITS + LENGTH_BITS;
   localparam int DATA_BITS  = ((FIELD_BITS + 7) / 8) * 8;
   localparam logic [LENGTH_BITS-1:0] LMAX = {LENGTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] LEN1 = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LEN2 = LENGTH_BITS'(2);

   typedef struct packed {
      lex_mode_type           mode;
      logic [7:0]             held;
      logic [7:0]             prior;
      logic                   qpct;
      logic [OFFSET_BITS-1:0] origin;
      logic [LENGTH_BITS-1:0] run;
   } lex_state_type;

   typedef struct packed {
      logic [4:0]             kind;
      logic [OFFSET_BITS-1:0] origin;
      logic [LENGTH_BITS-1:0] len;
   } token_type;

   typedef struct packed {
      lex_state_type st;
      logic          redo;
      logic          ev;
      token_type     tok;
   } step_type;

   typedef struct packed {
      logic [4:0]             kind;
      logic [OFFSET_BITS-1:0] start;
      logic [LENGTH_BITS-1:0] len;
      logic                   last;
   } result_type;

   localparam lex_state_type CLEAR_STATE = '{M_IDLE, 8'h00, 8'h00, 1'b0, '0, '0};

   function automatic logic [LENGTH_BITS-1:0] grow(logic [LENGTH_BITS-1:0] r);
      return (r == LMAX) ? r : r + LEN1;
   endfunction

   // one pass of the state transition for one byte
   function automatic step_type lex_step(lex_state_type s, logic [7:0] b,
                                         logic [OFFSET_BITS-1:0] pos);
      step_type     o;
      logic [7:0]   endc;
      logic         bits;
      kind_hit_type pk;
      kind_hit_type sk;
      kind_hit_type hk;
      o      = '0;
      o.st   = s;
      endc   = s.qpct ? CH_PCT : CH_DQUOTE;
      bits   = (s.mode == M_BIT) || (s.mode == M_BIT_END) || (s.mode == M_BIT_ESC);
      pk     = pair_kind(s.held, b);
      sk     = single_kind(b);
      hk     = single_kind(s.held);
      unique case (s.mode)
         M_WS: begin
            if (b <= CH_SPACE) o.st.run = grow(s.run);
            else if (b == CH_C2) begin
               o.st.mode = M_WS_C2;
               o.st.held = b;
            end else begin
               o.ev = 1'b1; o.tok = '{K_WS, s.origin, s.run};
               o.st.mode = M_IDLE; o.redo = 1'b1;
            end
         end
         M_WS_C2: begin
            if (b == CH_A0) begin
               o.st.run  = grow(grow(s.run));
               o.st.mode = M_WS;
            end else begin
               o.ev = 1'b1; o.tok = '{K_WS, s.origin, s.run};
               o.st.origin = pos - OFFSET_BITS'(1);
               o.st.run = LEN1; o.st.mode = M_IDENT; o.redo = 1'b1;
            end
         end
         M_START_C2: begin
            if (b == CH_A0) begin
               o.st.run = LEN2; o.st.mode = M_WS;
            end else begin
               o.st.run = LEN1; o.st.mode = M_IDENT; o.redo = 1'b1;
            end
         end
         M_DASH: begin
            if (b == CH_DASH) begin
               o.st.run = grow(s.run); o.st.mode = M_COMMENT;
            end else begin
               o.ev = 1'b1; o.tok = '{K_MINUS, s.origin, LEN1};
               o.st.mode = M_IDLE; o.redo = 1'b1;
            end
         end
         M_COMMENT: begin
            if (b == CH_LF) begin
               o.ev = 1'b1; o.tok = '{K_COMMENT, s.origin, s.run};
               o.st.mode = M_IDLE; o.redo = 1'b1;
            end else o.st.run = grow(s.run);
         end
         M_COMPOUND: begin
            o.ev = 1'b1;
            o.st.mode = M_IDLE;
            if (pk.hit) o.tok = '{pk.kind, s.origin, LEN2};
            else begin
               o.tok  = '{hk.kind, s.origin, LEN1};
               o.redo = 1'b1;
            end
         end
         M_EXT: begin
            o.st.run = grow(s.run);
            if (b == CH_BSL) o.st.mode = M_EXT_BS;
         end
         M_EXT_BS: begin
            if (b == CH_BSL) begin
               o.st.run = grow(s.run); o.st.mode = M_EXT;
            end else begin
               o.ev = 1'b1; o.tok = '{K_EXTID, s.origin, s.run};
               o.st.mode = M_IDLE; o.redo = 1'b1;
            end
         end
         M_NUM: begin
            if (num_byte(b)) begin
               o.st.run = grow(s.run); o.st.prior = b;
            end else if ((s.prior == 8'h65 || s.prior == 8'h45)
                         && (b == CH_PLUS || b == CH_DASH)) begin
               o.st.run = grow(s.run); o.st.mode = M_NUM_EXP;
            end else begin
               o.ev = 1'b1; o.tok = '{K_ABSLIT, s.origin, s.run};
               o.st.mode = M_IDLE; o.redo = 1'b1;
            end
         end
         M_NUM_EXP: begin
            if (is_digit(b)) o.st.run = grow(s.run);
            else begin
               o.ev = 1'b1; o.tok = '{K_ABSLIT, s.origin, s.run};
               o.st.mode = M_IDLE; o.redo = 1'b1;
            end
         end
         M_CHAR_OPEN: begin
            o.st.run = grow(s.run); o.st.mode = M_CHAR_TAIL;
         end
         M_CHAR_TAIL: begin
            o.st.run = grow(s.run);
            if (!b[7]) begin
               o.ev = 1'b1; o.tok = '{K_CHARLIT, s.origin, grow(s.run)};
               o.st.mode = M_IDLE;
            end
         end
         M_STR, M_BIT: begin
            o.st.run = grow(s.run);
            if (b == endc) o.st.mode = bits ? M_BIT_END : M_STR_END;
            else if (b == CH_BSL) o.st.mode = bits ? M_BIT_ESC : M_STR_ESC;
         end
         M_STR_END, M_BIT_END: begin
            if (b == endc) begin
               o.st.run = grow(s.run); o.st.mode = bits ? M_BIT : M_STR;
            end else begin
               o.ev = 1'b1; o.tok = '{bits ? K_BITLIT : K_STRLIT, s.origin, s.run};
               o.st.mode = M_IDLE; o.redo = 1'b1;
            end
         end
         M_STR_ESC, M_BIT_ESC: begin
            o.st.run = grow(s.run); o.st.mode = bits ? M_BIT : M_STR;
         end
         M_BASE: begin
            if (b == CH_DQUOTE || b == CH_PCT) begin
               o.st.run = grow(s.run); o.st.qpct = (b == CH_PCT); o.st.mode = M_BIT;
            end else begin
               o.st.mode = M_IDENT; o.redo = 1'b1;
            end
         end
         M_IDENT: begin
            if (b == CH_C2) begin
               o.st.mode = M_IDENT_C2; o.st.held = b;
            end else if (ident_byte(b)) o.st.run = grow(s.run);
            else begin
               o.ev = 1'b1; o.tok = '{K_IDENT, s.origin, s.run};
               o.st.mode = M_IDLE; o.redo = 1'b1;
            end
         end
         M_IDENT_C2: begin
            if (b == CH_A0) begin
               o.ev = 1'b1; o.tok = '{K_IDENT, s.origin, s.run};
               o.st.origin = pos - OFFSET_BITS'(1);
               o.st.run = LEN2; o.st.mode = M_WS;
            end else begin
               o.st.run = grow(s.run); o.st.mode = M_IDENT; o.redo = 1'b1;
            end
         end
         default: begin
            // idle: start a new token
            o.st.mode   = M_IDLE;
            o.st.origin = pos;
            o.st.run    = LEN1;
            if (b >= 8'h01 && b <= CH_SPACE) o.st.mode = M_WS;
            else if (b == CH_C2) begin
               o.st.mode = M_START_C2; o.st.run = '0; o.st.held = b;
            end else if (b == CH_DASH) o.st.mode = M_DASH;
            else if (is_compound_lead(b)) begin
               o.st.mode = M_COMPOUND; o.st.held = b;
            end else if (sk.hit) begin
               o.st.origin = s.origin; o.st.run = s.run;
               o.ev = 1'b1; o.tok = '{sk.kind, pos, LEN1};
            end else if (b == CH_BSL) o.st.mode = M_EXT;
            else if (is_digit(b)) begin
               o.st.mode = M_NUM; o.st.prior = b;
            end else if (b == CH_APOS) o.st.mode = M_CHAR_OPEN;
            else if (b == CH_DQUOTE || b == CH_PCT) begin
               o.st.mode = M_STR; o.st.qpct = (b == CH_PCT);
            end else if (b == 8'h62 || b == 8'h42 || b == 8'h6f || b == 8'h4f
                         || b == 8'h78 || b == 8'h58) o.st.mode = M_BASE;
            else if (is_letter(b) || b[7]) o.st.mode = M_IDENT;
            else begin
               o.st.origin = s.origin; o.st.run = s.run;
            end
         end
      endcase
      return o;
   endfunction

   // registers
   logic                   skip_ws_ff, skip_ws_in;
   logic                   skip_cmt_ff, skip_cmt_in;
   logic [31:0]            base_ff, base_in;
   lex_state_type          state_ff, state_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   result_type             slot_ff [3];
   result_type             slot_in [3];
   logic [1:0]             cnt_ff, cnt_in;

   // combinational working signals
   lex_state_type          walk;
   step_type               stp;
   logic                   active;
   logic [3:0]             cand_v;
   token_type              cand [4];
   result_type             fresh [3];
   logic [1:0]             fresh_n;
   logic                   keep;
   logic                   req_xfer;
   logic                   rsp_xfer;
   logic [OFFSET_BITS-1:0] prev_pos;
   kind_hit_type           held_kind;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tdata  = DATA_BITS'({slot_ff[0].len, slot_ff[0].start, slot_ff[0].kind});
   assign rsp_tlast  = slot_ff[0].last;
   assign prev_pos   = pos_ff - OFFSET_BITS'(1);
   assign held_kind  = single_kind(state_ff.held);

   // register writes
   always_comb begin
      skip_ws_in  = skip_ws_ff;
      skip_cmt_in = skip_cmt_ff;
      base_in     = base_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SKIP_WS:  skip_ws_in  = csr_data[0];
            REG_SKIP_CMT: skip_cmt_in = csr_data[0];
            REG_BASE:     base_in     = csr_data;
            default:      ;
         endcase
      end
   end

   // lex one byte: up to four passes, or a flush on the end byte
   always_comb begin
      walk   = state_ff;
      active = 1'b1;
      cand_v = '0;
      stp    = '0;
      for (int i = 0; i < 4; i++) begin
         cand[i] = '0;
      end
      if (req_tdata == 8'h00) begin
         case (state_ff.mode)
            M_WS: begin
               cand_v[0] = 1'b1; cand[0] = '{K_WS, state_ff.origin, state_ff.run};
            end
            M_WS_C2: begin
               cand_v[1:0] = 2'b11;
               cand[0] = '{K_WS, state_ff.origin, state_ff.run};
               cand[1] = '{K_IDENT, prev_pos, LEN1};
            end
            M_START_C2: begin
               cand_v[0] = 1'b1; cand[0] = '{K_IDENT, state_ff.origin, LEN1};
            end
            M_DASH: begin
               cand_v[0] = 1'b1; cand[0] = '{K_MINUS, state_ff.origin, LEN1};
            end
            M_COMMENT: begin
               cand_v[0] = 1'b1; cand[0] = '{K_COMMENT, state_ff.origin, state_ff.run};
            end
            M_COMPOUND: begin
               cand_v[0] = 1'b1;
               cand[0] = '{held_kind.kind, state_ff.origin, LEN1};
            end
            M_EXT, M_EXT_BS: begin
               cand_v[0] = 1'b1; cand[0] = '{K_EXTID, state_ff.origin, state_ff.run};
            end
            M_NUM, M_NUM_EXP: begin
               cand_v[0] = 1'b1; cand[0] = '{K_ABSLIT, state_ff.origin, state_ff.run};
            end
            M_CHAR_OPEN, M_CHAR_TAIL: begin
               cand_v[0] = 1'b1; cand[0] = '{K_CHARLIT, state_ff.origin, state_ff.run};
            end
            M_STR, M_STR_END, M_STR_ESC: begin
               cand_v[0] = 1'b1; cand[0] = '{K_STRLIT, state_ff.origin, state_ff.run};
            end
            M_BIT, M_BIT_END, M_BIT_ESC: begin
               cand_v[0] = 1'b1; cand[0] = '{K_BITLIT, state_ff.origin, state_ff.run};
            end
            M_BASE, M_IDENT: begin
               cand_v[0] = 1'b1; cand[0] = '{K_IDENT, state_ff.origin, state_ff.run};
            end
            M_IDENT_C2: begin
               cand_v[0] = 1'b1;
               cand[0] = '{K_IDENT, state_ff.origin, grow(state_ff.run)};
            end
            default: ;
         endcase
         walk = CLEAR_STATE;
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (active) begin
               stp       = lex_step(walk, req_tdata, pos_ff);
               walk      = stp.st;
               cand_v[i] = stp.ev;
               cand[i]   = stp.tok;
               active    = stp.redo;
            end
         end
      end
   end

   // drop skipped kinds and pack the tokens into result order
   always_comb begin
      fresh_n = 2'd0;
      keep    = 1'b0;
      for (int i = 0; i < 3; i++) begin
         fresh[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         keep = cand_v[i] && !(cand[i].kind == K_WS && skip_ws_ff)
                && !(cand[i].kind == K_COMMENT && skip_cmt_ff);
         if (keep && fresh_n != 2'd3) begin
            fresh[fresh_n].kind  = cand[i].kind;
            fresh[fresh_n].start = OFFSET_BITS'(base_ff) + cand[i].origin;
            fresh[fresh_n].len   = cand[i].len;
            fresh_n = fresh_n + 2'd1;
         end
      end
      if (fresh_n != 2'd0) fresh[fresh_n - 2'd1].last = 1'b1;
   end

   // lexer state and result buffer next values
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      slot_in  = slot_ff;
      if (req_xfer) begin
         state_in = walk;
         pos_in   = (req_tdata == 8'h00) ? '0 : pos_ff + OFFSET_BITS'(1);
         slot_in  = fresh;
         cnt_in   = fresh_n;
      end else if (rsp_xfer) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ws_ff  <= 1'b0;
         skip_cmt_ff <= 1'b0;
         base_ff     <= '0;
         state_ff    <= CLEAR_STATE;
         pos_ff      <= '0;
         cnt_ff      <= 2'd0;
      end else begin
         skip_ws_ff  <= skip_ws_in;
         skip_cmt_ff <= skip_cmt_in;
         base_ff     <= base_in;
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         cnt_ff      <= cnt_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

`include "vhdl_token_boundary_lexer_top_assert.svh"

   // the end byte leaves the lexer idle at offset zero
   `VTBL_ASSERT_NEXT(a_flush_clears, clock, reset,
      req_xfer && req_tdata == 8'h00, state_ff.mode == M_IDLE && pos_ff == '0)
   // only the final buffered token is marked last
   `VTBL_ASSERT_SAME(a_last_on_final, clock, reset, rsp_tvalid && rsp_tlast, cnt_ff == 2'd1)
   // a byte is never taken while more than one token waits
   `VTBL_ASSERT_SAME(a_no_overrun, clock, reset,
      req_xfer, cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_xfer))

endmodule
